// ===== design/pfg_pkg.sv =====
// Shared types, constants and helper functions for the phase-shift fringe pixel generator.
// Used by every module of the block; depends on nothing else.
package pfg_pkg;

    localparam int FRAME_ROWS = 1024;
    localparam int FRAME_COLS = 2048;
    localparam int MAX_IMAGES = 16;

    localparam int IDX_W     = 4;
    localparam int COORD_W   = 11;
    localparam int GRAY_W    = 8;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 4;
    localparam int PERIOD_W  = 12;
    localparam int COUNT_W   = 5;
    localparam int PHASE_W   = 16;
    localparam int HALF_W    = 16;
    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 8;

    localparam logic [COORD_W:0] ROW_LIMIT = (COORD_W + 1)'(FRAME_ROWS);
    localparam logic [COORD_W:0] COL_LIMIT = (COORD_W + 1)'(FRAME_COLS);
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_IMAGES);

    localparam int DIV_STAGES = COORD_W + PHASE_W;
    localparam int IDX_STEPS  = IDX_W + PHASE_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CORDIC_STEPS = 16;
    localparam int FRAC_BITS    = 20;
    localparam int XY_W         = 24;
    localparam int Z_W          = 18;
    localparam int NUM_W        = 32;
    localparam logic signed [XY_W-1:0] CORDIC_X0 = XY_W'(636751);
    localparam logic signed [NUM_W-1:0] GRAY_BIAS = NUM_W'(256) << FRAC_BITS;

    localparam logic [PHASE_W-1:0] QUARTER_TURN = PHASE_W'(16384);
    localparam logic [PHASE_W-1:0] HALF_TURN    = PHASE_W'(32768);
    localparam logic [PHASE_W-1:0] THREE_QUARTER = PHASE_W'(49152);

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_ORIGIN = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_SIZE   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MARK_ORIGIN    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MARK_SIZE      = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MARK_ENABLE    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRINGE_PERIOD  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COUNT    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_OFFSET   = 4'd7;

    typedef struct packed {
        logic               blank;
        logic [COORD_W-1:0] rel;
        logic [IDX_W-1:0]   idx;
    } pfg_item_t;

    typedef struct packed {
        logic               valid;
        logic               blank;
        logic [PHASE_W-1:0] phase;
    } pfg_phase_t;

    function automatic logic signed [Z_W-1:0] pfg_atan(input int k);
        logic signed [Z_W-1:0] a;
        case (k)
            0:       a = Z_W'(8192);
            1:       a = Z_W'(4836);
            2:       a = Z_W'(2555);
            3:       a = Z_W'(1297);
            4:       a = Z_W'(651);
            5:       a = Z_W'(326);
            6:       a = Z_W'(163);
            7:       a = Z_W'(81);
            8:       a = Z_W'(41);
            9:       a = Z_W'(20);
            10:      a = Z_W'(10);
            11:      a = Z_W'(5);
            12:      a = Z_W'(3);
            default: a = Z_W'(1);
        endcase
        return a;
    endfunction

endpackage

// ===== design/pfg_front.sv =====
// Front stage: takes request beats, checks frame, pattern and mark rectangles.
// Hands a classified item to the queue. Depends on pfg_pkg.
module pfg_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pfg_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic [pfg_pkg::CFG_W-1:0]     pattern_origin,
    input  logic [pfg_pkg::CFG_W-1:0]     pattern_size,
    input  logic [pfg_pkg::CFG_W-1:0]     mark_origin,
    input  logic [pfg_pkg::CFG_W-1:0]     mark_size,
    input  logic                          mark_enable,
    input  logic                          q_full,
    output logic                          push,
    output pfg_pkg::pfg_item_t            push_item
);

    localparam int CW = pfg_pkg::COORD_W;
    localparam int HW = pfg_pkg::HALF_W;

    function automatic logic in_rect(input logic [CW-1:0] r, input logic [CW-1:0] c,
                                     input logic [pfg_pkg::CFG_W-1:0] origin,
                                     input logic [pfg_pkg::CFG_W-1:0] size);
        logic [HW:0] r_end;
        logic [HW:0] c_end;
        r_end = {1'b0, origin[2*HW-1:HW]} + {1'b0, size[2*HW-1:HW]};
        c_end = {1'b0, origin[HW-1:0]} + {1'b0, size[HW-1:0]};
        return ((HW)'(r) >= origin[2*HW-1:HW]) && ((HW + 1)'(r) < r_end) &&
               ((HW)'(c) >= origin[HW-1:0]) && ((HW + 1)'(c) < c_end);
    endfunction

    logic                   front_valid_reg;
    logic                   front_valid_next;
    pfg_pkg::pfg_item_t     front_item_reg;
    pfg_pkg::pfg_item_t     front_item_next;
    logic [CW-1:0]          row;
    logic [CW-1:0]          col;
    logic                   accept;
    logic                   shown;

    assign row      = s_tdata[pfg_pkg::IDX_W +: CW];
    assign col      = s_tdata[pfg_pkg::IDX_W + CW +: CW];
    assign push     = front_valid_reg && !q_full;
    assign s_tready = !front_valid_reg || !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        shown = ({1'b0, row} < pfg_pkg::ROW_LIMIT) && ({1'b0, col} < pfg_pkg::COL_LIMIT) &&
                in_rect(row, col, pattern_origin, pattern_size) &&
                !(mark_enable && in_rect(row, col, mark_origin, mark_size));
        front_item_next.blank = !shown;
        front_item_next.rel   = row - pattern_origin[HW +: CW];
        front_item_next.idx   = s_tdata[pfg_pkg::IDX_W-1:0];
        if (accept)
        begin
            front_valid_next = 1'b1;
        end
        else if (push)
        begin
            front_valid_next = 1'b0;
        end
        else
        begin
            front_valid_next = front_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            front_item_reg <= front_item_next;
        end
    end

    assign push_item = front_item_reg;

endmodule

// ===== design/pfg_queue.sv =====
// Short queue of classified items between the front stage and the back pipeline.
// Depends on pfg_pkg.
module pfg_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  pfg_pkg::pfg_item_t push_item,
    input  logic               pop,
    output pfg_pkg::pfg_item_t pop_item,
    output logic               full,
    output logic               empty
);

    pfg_pkg::pfg_item_t                 mem_reg [pfg_pkg::QUEUE_DEPTH];
    logic [pfg_pkg::QPTR_W-1:0]         wr_ptr_reg;
    logic [pfg_pkg::QPTR_W-1:0]         wr_ptr_next;
    logic [pfg_pkg::QPTR_W-1:0]         rd_ptr_reg;
    logic [pfg_pkg::QPTR_W-1:0]         rd_ptr_next;
    logic [pfg_pkg::QCNT_W-1:0]         count_reg;
    logic [pfg_pkg::QCNT_W-1:0]         count_next;

    assign full     = (count_reg == pfg_pkg::QCNT_W'(pfg_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("Queue written while full.");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("Queue read while empty.");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("Queue count did not follow a write.");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= pfg_pkg::QCNT_W'(pfg_pkg::QUEUE_DEPTH))
        else $error("Queue count beyond depth.");

endmodule

// ===== design/pfg_phase.sv =====
// Back pipeline, first half: restoring dividers one bit per stage for the row term
// and the index term, then the phase sum. Depends on pfg_pkg.
module pfg_phase (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  pfg_pkg::pfg_item_t            in_item,
    input  logic [pfg_pkg::PERIOD_W-1:0]  fringe_period,
    input  logic [pfg_pkg::COUNT_W-1:0]   image_count,
    input  logic [pfg_pkg::PHASE_W-1:0]   phase_offset,
    output pfg_pkg::pfg_phase_t           ph
);

    localparam int NS = pfg_pkg::DIV_STAGES;
    localparam int PW = pfg_pkg::PERIOD_W;
    localparam int KW = pfg_pkg::COUNT_W;
    localparam int QW = pfg_pkg::PHASE_W;
    localparam int CW = pfg_pkg::COORD_W;
    localparam int IW = pfg_pkg::IDX_W;

    typedef struct packed {
        logic          blank;
        logic [CW-1:0] rel;
        logic [IW-1:0] idx;
        logic [PW-1:0] rem;
        logic [QW-1:0] frac;
        logic [KW-1:0] irem;
        logic [QW-1:0] iq;
    } pfg_div_t;

    function automatic pfg_div_t div_step(input pfg_div_t p, input int s,
                                          input logic [PW-1:0] per, input logic [KW-1:0] cnt);
        pfg_div_t      n;
        logic [PW:0]   r_try;
        logic [KW:0]   i_try;
        logic          q_bit;
        logic          i_bit;
        n     = p;
        r_try = {p.rem, p.rel[CW-1]};
        q_bit = (r_try >= {1'b0, per});
        if (q_bit)
        begin
            r_try = r_try - {1'b0, per};
        end
        n.rem  = r_try[PW-1:0];
        n.rel  = {p.rel[CW-2:0], 1'b0};
        n.frac = {p.frac[QW-2:0], q_bit};
        if (s < pfg_pkg::IDX_STEPS)
        begin
            i_try = {p.irem, p.idx[IW-1]};
            i_bit = (i_try >= {1'b0, cnt});
            if (i_bit)
            begin
                i_try = i_try - {1'b0, cnt};
            end
            n.irem = i_try[KW-1:0];
            n.idx  = {p.idx[IW-2:0], 1'b0};
            n.iq   = {p.iq[QW-2:0], i_bit};
        end
        return n;
    endfunction

    pfg_div_t            div_reg  [NS];
    pfg_div_t            div_next [NS];
    pfg_div_t            seed;
    logic [NS-1:0]       valid_reg;
    logic [NS-1:0]       valid_next;
    logic [PW-1:0]       per_eff;
    logic [KW-1:0]       cnt_eff;
    pfg_pkg::pfg_phase_t ph_reg;
    pfg_pkg::pfg_phase_t ph_next;

    always_comb
    begin
        per_eff = (fringe_period == '0) ? PW'(1) : fringe_period;
        if (image_count == '0)
        begin
            cnt_eff = KW'(1);
        end
        else if (image_count > pfg_pkg::COUNT_MAX)
        begin
            cnt_eff = pfg_pkg::COUNT_MAX;
        end
        else
        begin
            cnt_eff = image_count;
        end

        seed       = '0;
        seed.blank = in_item.blank;
        seed.rel   = in_item.rel;
        seed.idx   = in_item.idx;
        div_next[0] = div_step(seed, 0, per_eff, cnt_eff);
        for (int s = 1; s < NS; s++)
        begin
            div_next[s] = div_step(div_reg[s-1], s, per_eff, cnt_eff);
        end
        valid_next = {valid_reg[NS-2:0], in_valid};

        ph_next.valid = valid_reg[NS-1];
        ph_next.blank = div_reg[NS-1].blank;
        ph_next.phase = div_reg[NS-1].frac + div_reg[NS-1].iq + phase_offset;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ph_reg    <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
            ph_reg    <= ph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s < NS; s++)
            begin
                div_reg[s] <= div_next[s];
            end
        end
    end

    assign ph = ph_reg;

endmodule

// ===== design/pfg_cordic.sv =====
// Back pipeline, second half: quadrant fold, 16 CORDIC rotation stages, gray mapping
// and the output register. Depends on pfg_pkg.
module pfg_cordic (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pfg_pkg::pfg_phase_t           ph,
    output logic                          adv,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pfg_pkg::M_DATA_W-1:0]  m_tdata
);

    localparam int NS = pfg_pkg::CORDIC_STEPS;
    localparam int XW = pfg_pkg::XY_W;
    localparam int ZW = pfg_pkg::Z_W;
    localparam int NW = pfg_pkg::NUM_W;
    localparam int QW = pfg_pkg::PHASE_W;
    localparam int GW = pfg_pkg::GRAY_W;
    localparam int SH = pfg_pkg::FRAC_BITS + 1;

    typedef struct packed {
        logic                 blank;
        logic                 neg;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } pfg_rot_t;

    function automatic pfg_rot_t rot_step(input pfg_rot_t p, input int k);
        pfg_rot_t             n;
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;
        n  = p;
        xs = $signed(p.x) >>> k;
        ys = $signed(p.y) >>> k;
        if (!p.z[ZW-1])
        begin
            n.x = p.x - ys;
            n.y = p.y + xs;
            n.z = p.z - pfg_pkg::pfg_atan(k);
        end
        else
        begin
            n.x = p.x + ys;
            n.y = p.y - xs;
            n.z = p.z + pfg_pkg::pfg_atan(k);
        end
        return n;
    endfunction

    pfg_rot_t              fold_reg;
    pfg_rot_t              fold_next;
    logic                  fold_valid_reg;
    pfg_rot_t              rot_reg  [NS];
    pfg_rot_t              rot_next [NS];
    logic [NS-1:0]         rot_valid_reg;
    logic [NS-1:0]         rot_valid_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [GW-1:0]         out_gray_reg;
    logic [GW-1:0]         out_gray_next;
    logic [QW-1:0]         folded;
    logic signed [XW-1:0]  x_fin;
    logic signed [NW-1:0]  x_ext;
    logic signed [NW-1:0]  num;

    assign adv      = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_gray_reg;

    always_comb
    begin
        fold_next.blank = ph.blank;
        fold_next.neg   = (ph.phase >= pfg_pkg::QUARTER_TURN) &&
                          (ph.phase < pfg_pkg::THREE_QUARTER);
        folded          = fold_next.neg ? ph.phase - pfg_pkg::HALF_TURN : ph.phase;
        fold_next.x     = pfg_pkg::CORDIC_X0;
        fold_next.y     = '0;
        fold_next.z     = {{(ZW - QW){folded[QW-1]}}, folded};

        rot_next[0] = rot_step(fold_reg, 0);
        for (int k = 1; k < NS; k++)
        begin
            rot_next[k] = rot_step(rot_reg[k-1], k);
        end
        rot_valid_next = {rot_valid_reg[NS-2:0], fold_valid_reg};

        x_fin = rot_reg[NS-1].neg ? -rot_reg[NS-1].x : rot_reg[NS-1].x;
        x_ext = {{(NW - XW){x_fin[XW-1]}}, x_fin};
        num   = (x_ext <<< 8) - x_ext + pfg_pkg::GRAY_BIAS;
        if (rot_reg[NS-1].blank || num[NW-1])
        begin
            out_gray_next = '0;
        end
        else if (|num[NW-2:SH+GW])
        begin
            out_gray_next = '1;
        end
        else
        begin
            out_gray_next = num[SH +: GW];
        end
        out_valid_next = rot_valid_reg[NS-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_valid_reg <= 1'b0;
            rot_valid_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            fold_valid_reg <= ph.valid;
            rot_valid_reg  <= rot_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fold_reg     <= fold_next;
            out_gray_reg <= out_gray_next;
            for (int k = 0; k < NS; k++)
            begin
                rot_reg[k] <= rot_next[k];
            end
        end
    end

endmodule

// ===== design/phase_shift_fringe_pixel_generator.sv =====
// Phase-shift fringe pixel generator: configuration registers, front stage, queue, back pipeline.
// Throughput: one beat per cycle unless the output stalls; the back pipeline (27 divider stages,
// fold, 16 CORDIC stages) advances as a whole whenever the output register is empty or taken.
// Reset clears all valid state and loads the register reset values; no clearing pass is needed.
// Depends on pfg_pkg, pfg_front, pfg_queue, pfg_phase and pfg_cordic.
module phase_shift_fringe_pixel_generator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pfg_pkg::S_DATA_W-1:0]   s_tdata,   // image_index, pixel_row, pixel_col, pad
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pfg_pkg::M_DATA_W-1:0]   m_tdata,   // gray_value
    input  logic                           cfg_we,
    input  logic [pfg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pfg_pkg::CFG_W-1:0]      cfg_wdata
);

    logic [pfg_pkg::CFG_W-1:0]      pattern_origin_reg;
    logic [pfg_pkg::CFG_W-1:0]      pattern_size_reg;
    logic [pfg_pkg::CFG_W-1:0]      mark_origin_reg;
    logic [pfg_pkg::CFG_W-1:0]      mark_size_reg;
    logic                           mark_enable_reg;
    logic [pfg_pkg::PERIOD_W-1:0]   fringe_period_reg;
    logic [pfg_pkg::COUNT_W-1:0]    image_count_reg;
    logic [pfg_pkg::PHASE_W-1:0]    phase_offset_reg;

    logic                           push;
    pfg_pkg::pfg_item_t             push_item;
    logic                           pop;
    pfg_pkg::pfg_item_t             pop_item;
    logic                           q_full;
    logic                           q_empty;
    logic                           adv;
    pfg_pkg::pfg_phase_t            ph;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_origin_reg <= '0;
            pattern_size_reg   <= '0;
            mark_origin_reg    <= '0;
            mark_size_reg      <= '0;
            mark_enable_reg    <= 1'b0;
            fringe_period_reg  <= pfg_pkg::PERIOD_W'(16);
            image_count_reg    <= pfg_pkg::COUNT_W'(4);
            phase_offset_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pfg_pkg::REG_PATTERN_ORIGIN: pattern_origin_reg <= cfg_wdata;
                pfg_pkg::REG_PATTERN_SIZE:   pattern_size_reg   <= cfg_wdata;
                pfg_pkg::REG_MARK_ORIGIN:    mark_origin_reg    <= cfg_wdata;
                pfg_pkg::REG_MARK_SIZE:      mark_size_reg      <= cfg_wdata;
                pfg_pkg::REG_MARK_ENABLE:    mark_enable_reg    <= cfg_wdata[0];
                pfg_pkg::REG_FRINGE_PERIOD:  fringe_period_reg  <= cfg_wdata[pfg_pkg::PERIOD_W-1:0];
                pfg_pkg::REG_IMAGE_COUNT:    image_count_reg    <= cfg_wdata[pfg_pkg::COUNT_W-1:0];
                pfg_pkg::REG_PHASE_OFFSET:   phase_offset_reg   <= cfg_wdata[pfg_pkg::PHASE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign pop = adv && !q_empty;

    pfg_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .pattern_origin (pattern_origin_reg),
        .pattern_size   (pattern_size_reg),
        .mark_origin    (mark_origin_reg),
        .mark_size      (mark_size_reg),
        .mark_enable    (mark_enable_reg),
        .q_full         (q_full),
        .push           (push),
        .push_item      (push_item)
    );

    pfg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    pfg_phase u_phase (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .in_valid      (!q_empty),
        .in_item       (pop_item),
        .fringe_period (fringe_period_reg),
        .image_count   (image_count_reg),
        .phase_offset  (phase_offset_reg),
        .ph            (ph)
    );

    pfg_cordic u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .ph       (ph),
        .adv      (adv),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
